### rtl/scfla_pkg.sv
package scfla_pkg;

	// Class field width covers the largest supported class count (28).
	localparam int unsigned CLS_MAX_W = 5;

	typedef enum logic [2:0] {
		ST_HIT         = 3'd0,
		ST_MISS        = 3'd1,
		ST_ALLOC_BIG   = 3'd2,
		ST_FREE_CACHED = 3'd3,
		ST_FREE_FULL   = 3'd4,
		ST_FREE_BIG    = 3'd5
	} status_t;

	// Classified request handed from the front to the back through the queue.
	typedef struct packed {
		logic                 is_free;
		logic                 big;
		logic [CLS_MAX_W-1:0] cls;
		logic [31:0]          blk;     // raw size when big, else class size
		logic [31:0]          handle;
	} req_t;

endpackage

### rtl/scfla_front.sv
module scfla_front #(
	parameter int unsigned NUM_CLASSES = 14,
	parameter int unsigned MIN_SHIFT   = 3
) (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [31:0]        size,
	input  logic [31:0]        handle,
	output logic               push_valid,
	input  logic               push_ready,
	output scfla_pkg::req_t    push_data
);

	logic [scfla_pkg::CLS_MAX_W-1:0] cls;
	logic                            big;
	logic [31:0]                     csize;

	// Parallel compare against every class threshold; the smallest match wins.
	always_comb begin
		cls   = '0;
		big   = 1'b1;
		csize = '0;
		for (int i = int'(NUM_CLASSES) - 1; i >= 0; i--) begin
			if (64'(size) < (64'd1 << (i + int'(MIN_SHIFT)))) begin
				cls   = scfla_pkg::CLS_MAX_W'(i);
				big   = 1'b0;
				csize = 32'(64'd1 << (i + int'(MIN_SHIFT)));
			end
		end
	end

	assign push_valid        = in_valid;
	assign in_ready          = push_ready;
	assign push_data.is_free = req_type;
	assign push_data.big     = big;
	assign push_data.cls     = cls;
	assign push_data.blk     = big ? size : csize;
	assign push_data.handle  = handle;

endmodule

### rtl/scfla_queue.sv
module scfla_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  scfla_pkg::req_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output scfla_pkg::req_t pop_data
);

	scfla_pkg::req_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

### rtl/scfla_back.sv
module scfla_back #(
	parameter int unsigned NUM_CLASSES = 14,
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned ADDR_WIDTH  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  scfla_pkg::req_t     req,
	output logic                out_valid,
	input  logic                out_ready,
	output scfla_pkg::status_t  status,
	output logic [31:0]         out_handle,
	output logic [3:0]          class_index,
	output logic [31:0]         block_size
);

	localparam int unsigned CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned MEM_D = NUM_CLASSES * STACK_DEPTH;
	localparam int unsigned IDX_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
	localparam int unsigned OUT_W = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

	logic [ADDR_WIDTH-1:0] mem [MEM_D];
	logic [ADDR_WIDTH-1:0] rd_q;
	logic [CNT_W-1:0]      count_q [NUM_CLASSES];

	logic                  valid_s2;
	scfla_pkg::status_t    status_s2;
	logic [3:0]            cls_s2;
	logic [31:0]           blk_s2;

	logic [CLS_W-1:0]      cls;
	logic [CNT_W-1:0]      cnt;
	logic                  hit;
	logic                  full;
	logic                  advance;
	logic [IDX_W-1:0]      base;
	logic [IDX_W-1:0]      addr;
	logic                  wr_en;
	logic                  rd_en;
	scfla_pkg::status_t    st;
	logic [31:0]           blk;

	assign cls       = req.cls[CLS_W-1:0];
	assign cnt       = count_q[cls];
	assign hit       = (cnt != '0);
	assign full      = (cnt == CNT_W'(STACK_DEPTH));
	assign req_ready = !valid_s2 || out_ready;
	assign advance   = req_valid && req_ready;
	assign base      = IDX_W'(cls * STACK_DEPTH);
	assign addr      = req.is_free ? (base + IDX_W'(cnt)) : (base + IDX_W'(cnt - CNT_W'(1)));

	always_comb begin
		st    = scfla_pkg::ST_MISS;
		blk   = '0;
		wr_en = 1'b0;
		rd_en = 1'b0;
		if (req.big) begin
			st  = req.is_free ? scfla_pkg::ST_FREE_BIG : scfla_pkg::ST_ALLOC_BIG;
			blk = req.blk;
		end else if (!req.is_free) begin
			if (hit) begin
				st    = scfla_pkg::ST_HIT;
				rd_en = 1'b1;
			end else begin
				st  = scfla_pkg::ST_MISS;
				blk = req.blk;
			end
		end else begin
			if (full) begin
				st  = scfla_pkg::ST_FREE_FULL;
				blk = req.blk;
			end else begin
				st    = scfla_pkg::ST_FREE_CACHED;
				wr_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(NUM_CLASSES); i++) count_q[i] <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				if (rd_en) count_q[cls] <= cnt - CNT_W'(1);
				if (wr_en) count_q[cls] <= cnt + CNT_W'(1);
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= st;
			cls_s2    <= req.big ? 4'd0 : req.cls[3:0];
			blk_s2    <= blk;
			if (wr_en) mem[addr] <= ADDR_WIDTH'(req.handle);
			if (rd_en) rd_q <= mem[addr];
		end
	end

	assign out_valid   = valid_s2;
	assign status      = status_s2;
	assign class_index = cls_s2;
	assign block_size  = blk_s2;
	assign out_handle  = (status_s2 == scfla_pkg::ST_HIT) ? 32'(rd_q[OUT_W-1:0]) : 32'd0;

endmodule

### rtl/size_class_free_list_allocator_top.sv
// Size-class free-list allocator. Each request is an allocate (req_type 0) or a
// free (req_type 1) with a byte size; the size selects the first class i with
// size < 1 << (i + MIN_SHIFT), and each class keeps a LIFO stack of up to
// STACK_DEPTH cached handles. An allocate pops a handle (status hit) or, on an
// empty stack, reports a miss with the class size to fetch. A free pushes the
// handle or, on a full stack, reports the class size to release. Sizes beyond
// the last class go straight to backing memory with the raw size. Exactly one
// result comes out per request, in request order. The block sustains one
// request per cycle while out_ready holds: the front classifies in the
// accepting cycle, a two-entry queue decouples it from the back, and the back
// does one count update and one access of the single-port stack memory per
// cycle. An accepted request is written into the queue, then into the back's
// result register, where its result is valid. No clearing pass runs after
// reset; only the per-class counts and the control state are cleared.
module size_class_free_list_allocator_top #(
	parameter int unsigned NUM_CLASSES = 14,
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned MIN_SHIFT   = 3,
	parameter int unsigned ADDR_WIDTH  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [31:0]         size,
	input  logic [31:0]         handle,
	output logic                out_valid,
	input  logic                out_ready,
	output scfla_pkg::status_t  status,
	output logic [31:0]         out_handle,
	output logic [3:0]          class_index,
	output logic [31:0]         block_size
);

	logic            push_valid;
	logic            push_ready;
	scfla_pkg::req_t push_data;
	logic            q_valid;
	logic            q_ready;
	scfla_pkg::req_t q_data;

	// Classify the request by size and hand it to the queue.
	scfla_front #(
		.NUM_CLASSES (NUM_CLASSES),
		.MIN_SHIFT   (MIN_SHIFT)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.size       (size),
		.handle     (handle),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Hold classified requests while the back stalls on the output.
	scfla_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	// Push or pop the class stack and register the result.
	scfla_back #(
		.NUM_CLASSES (NUM_CLASSES),
		.STACK_DEPTH (STACK_DEPTH),
		.ADDR_WIDTH  (ADDR_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (q_valid),
		.req_ready   (q_ready),
		.req         (q_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_handle  (out_handle),
		.class_index (class_index),
		.block_size  (block_size)
	);

	// A bypassed request never names a class.
	a_big_no_class: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == scfla_pkg::ST_ALLOC_BIG || status == scfla_pkg::ST_FREE_BIG))
			|-> (class_index == 4'd0))
		else $error("bypassed request carries a class index");

	// Served from the cache means nothing moves to or from backing memory.
	a_cached_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == scfla_pkg::ST_HIT || status == scfla_pkg::ST_FREE_CACHED))
			|-> (block_size == 32'd0))
		else $error("cached request reports a backing size");

	// Only a hit returns a handle.
	a_handle_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != scfla_pkg::ST_HIT) |-> (out_handle == 32'd0))
		else $error("handle returned without a hit");

	// An accepted request is in the queue at the next edge.
	a_queue_takes_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> q_valid)
		else $error("accepted request lost before the back");

endmodule
